>>> src/rspx_pkg.sv
package rspx_pkg;

	// phase and field widths
	localparam int ANGLE_BITS   = 16;
	localparam int PHASE_W      = ANGLE_BITS;
	localparam int MAX_BEAMS    = 1024;
	localparam int RANGE_W      = 16;
	localparam int INDEX_W      = 10;
	localparam int OFF_W        = 13;
	localparam int XY_W         = 18;
	localparam int Z_W          = 17;
	localparam int TRIG_W       = 16;
	localparam int CFG_W        = 16;
	localparam int CFG_ADDR_W   = 2;
	localparam int IN_DATA_W    = 48;
	localparam int OUT_DATA_W   = 56;

	// cordic constants, angles scaled so that 2^32 is one turn
	localparam int CORDIC_ITERS = 20;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032875;
	localparam logic signed [31:0] QUAD_BIAS   = 32'sd536870912;

	// register indexes of the configuration port
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_START_ANGLE = 2'd0,
		REG_ANGLE_STEP  = 2'd1,
		REG_AXIS_OFFSET = 2'd2
	} cfg_reg_t;

	// one cordic lane: vector, residual angle and quadrant
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [1:0]         q;
	} cordic_lane_t;

	// one item after the sine/cosine units
	typedef struct packed {
		logic [RANGE_W-1:0]       range_mm;
		logic signed [TRIG_W-1:0] cb;
		logic signed [TRIG_W-1:0] sb;
		logic signed [TRIG_W-1:0] ca;
		logic signed [TRIG_W-1:0] sa;
	} trig_item_t;

	// arctangent of 2^-i in phase units
	function automatic logic signed [31:0] atan_phase(input int i);
		logic signed [31:0] r;
		case (i)
			0:       r = 32'sd536870912;
			1:       r = 32'sd316933406;
			2:       r = 32'sd167458907;
			3:       r = 32'sd85004756;
			4:       r = 32'sd42667331;
			5:       r = 32'sd21354465;
			6:       r = 32'sd10679838;
			7:       r = 32'sd5340245;
			8:       r = 32'sd2670163;
			9:       r = 32'sd1335087;
			10:      r = 32'sd667544;
			11:      r = 32'sd333772;
			12:      r = 32'sd166886;
			13:      r = 32'sd83443;
			14:      r = 32'sd41722;
			15:      r = 32'sd20861;
			16:      r = 32'sd10430;
			17:      r = 32'sd5215;
			18:      r = 32'sd2608;
			19:      r = 32'sd1304;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// round a 2^30 scaled value half up to q1.15 and saturate
	function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [31:0] v);
		logic signed [32:0] t;
		logic signed [32:0] s;
		logic signed [TRIG_W-1:0] r;
		t = {v[31], v} + 33'sd16384;
		s = t >>> 15;
		if (s > 33'sd32767) begin
			r = 16'sh7fff;
		end else if (s < -33'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = s[TRIG_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> src/rspx_cordic.sv
module rspx_cordic import rspx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [RANGE_W-1:0] range_mm,
	input  logic [PHASE_W-1:0] phase_b,
	input  logic [PHASE_W-1:0] phase_a,
	output logic               out_valid,
	input  logic               out_ready,
	output trig_item_t         out_item
);

	localparam int N = CORDIC_ITERS;

	// stage k holds the vectors after k micro-rotations
	cordic_lane_t       b_sn   [0:N];
	cordic_lane_t       a_sn   [0:N];
	logic [RANGE_W-1:0] rng_sn [0:N];
	logic [N:0]         vld_sn;
	logic [N+1:0]       adv;
	logic               out_vld_q;
	trig_item_t         out_item_q;

	// quadrant split and gain-compensated start vector
	function automatic cordic_lane_t lane_init(input logic [PHASE_W-1:0] ph);
		cordic_lane_t l;
		logic [31:0] biased;
		biased = {ph, {(32-PHASE_W){1'b0}}} + 32'h2000_0000;
		l.q = biased[31:30];
		l.z = $signed({2'b00, biased[29:0]}) - QUAD_BIAS;
		l.x = CORDIC_GAIN;
		l.y = 32'sd0;
		return l;
	endfunction

	// one micro-rotation towards zero residual
	function automatic cordic_lane_t lane_step(input cordic_lane_t l, input int i);
		cordic_lane_t n;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		dx = $signed(l.y) >>> i;
		dy = $signed(l.x) >>> i;
		n.q = l.q;
		if (!l.z[31]) begin
			n.x = $signed(l.x) - dx;
			n.y = $signed(l.y) + dy;
			n.z = $signed(l.z) - atan_phase(i);
		end else begin
			n.x = $signed(l.x) + dx;
			n.y = $signed(l.y) - dy;
			n.z = $signed(l.z) + atan_phase(i);
		end
		return n;
	endfunction

	// map through the quadrant and round to q1.15
	function automatic logic signed [2*TRIG_W-1:0] lane_out(input cordic_lane_t l);
		logic signed [31:0] c;
		logic signed [31:0] s;
		case (l.q)
			2'd0: begin
				c = l.x;
				s = l.y;
			end
			2'd1: begin
				c = -$signed(l.y);
				s = l.x;
			end
			2'd2: begin
				c = -$signed(l.x);
				s = -$signed(l.y);
			end
			default: begin
				c = l.y;
				s = -$signed(l.x);
			end
		endcase
		return {to_q15(c), to_q15(s)};
	endfunction

	// ready chain: a stage moves when empty or when the next one moves
	assign adv[N+1] = !out_vld_q || out_ready;
	genvar g;
	generate
		for (g = 0; g <= N; g++) begin : g_adv
			assign adv[g] = !vld_sn[g] || adv[g+1];
		end
	endgenerate
	assign in_ready = adv[0];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn[0] <= 1'b0;
		end else if (adv[0]) begin
			vld_sn[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && in_valid) begin
			b_sn[0]   <= lane_init(phase_b);
			a_sn[0]   <= lane_init(phase_a);
			rng_sn[0] <= range_mm;
		end
	end

	// micro-rotation stages
	generate
		for (g = 1; g <= N; g++) begin : g_iter
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sn[g] <= 1'b0;
				end else if (adv[g]) begin
					vld_sn[g] <= vld_sn[g-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv[g] && vld_sn[g-1]) begin
					b_sn[g]   <= lane_step(b_sn[g-1], g - 1);
					a_sn[g]   <= lane_step(a_sn[g-1], g - 1);
					rng_sn[g] <= rng_sn[g-1];
				end
			end
		end
	endgenerate

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv[N+1]) begin
			out_vld_q <= vld_sn[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[N+1] && vld_sn[N]) begin
			out_item_q.range_mm       <= rng_sn[N];
			{out_item_q.cb, out_item_q.sb} <= lane_out(b_sn[N]);
			{out_item_q.ca, out_item_q.sa} <= lane_out(a_sn[N]);
		end
	end

	assign out_valid = out_vld_q;
	assign out_item  = out_item_q;

	// back-pressure only reaches the entry when every stage is occupied
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_sn) && out_vld_q && !out_ready)
		else $error("cordic stalled with a free stage");

	// a stalled last rotation stage keeps its item
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sn[N] && !adv[N+1] |=> vld_sn[N])
		else $error("cordic item lost under stall");

	// an accepted transfer always lands in the entry stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_sn[0])
		else $error("cordic entry dropped a transfer");

endmodule

>>> src/rspx_project.sv
module rspx_project import rspx_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  trig_item_t              in_item,
	input  logic signed [OFF_W-1:0] axis_offset_mm,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [XY_W-1:0]  point_x,
	output logic signed [XY_W-1:0]  point_y,
	output logic signed [Z_W-1:0]   point_z
);

	localparam int RSB_W  = RANGE_W + 1 + TRIG_W;
	localparam int OFFP_W = OFF_W + TRIG_W;
	localparam int PX_W   = RSB_W + TRIG_W;
	localparam int SUM_W  = PX_W + 2;
	localparam logic signed [SUM_W-1:0] RND30 = SUM_W'(64'sd1 <<< 29);

	// stage 1: range products and offset products
	logic                     vld_s1;
	logic signed [RSB_W-1:0]  rsb_s1;
	logic signed [RSB_W-1:0]  rcb_s1;
	logic signed [OFFP_W-1:0] offs_s1;
	logic signed [OFFP_W-1:0] offc_s1;
	logic signed [TRIG_W-1:0] ca_s1;
	logic signed [TRIG_W-1:0] sa_s1;
	// stage 2: rotation products and rounded z
	logic                     vld_s2;
	logic signed [PX_W-1:0]   px_s2;
	logic signed [PX_W-1:0]   py_s2;
	logic signed [Z_W-1:0]    z_s2;
	logic signed [OFFP_W-1:0] offs_s2;
	logic signed [OFFP_W-1:0] offc_s2;
	// stage 3: output register
	logic                     vld_s3;
	logic signed [XY_W-1:0]   x_s3;
	logic signed [XY_W-1:0]   y_s3;
	logic signed [Z_W-1:0]    z_s3;

	logic adv1, adv2, adv3;

	logic signed [RANGE_W:0]  r_d;
	logic signed [RSB_W-1:0]  rsb_d;
	logic signed [RSB_W-1:0]  rcb_d;
	logic signed [OFFP_W-1:0] offs_d;
	logic signed [OFFP_W-1:0] offc_d;
	logic signed [PX_W-1:0]   px_d;
	logic signed [PX_W-1:0]   py_d;
	logic signed [RSB_W:0]    zt_d;
	logic signed [RSB_W:0]    zs_d;
	logic signed [Z_W-1:0]    z_d;
	logic signed [SUM_W-1:0]  offx_d;
	logic signed [SUM_W-1:0]  offy_d;
	logic signed [SUM_W-1:0]  sx_d;
	logic signed [SUM_W-1:0]  sy_d;
	logic signed [SUM_W-1:0]  xr_d;
	logic signed [SUM_W-1:0]  yr_d;
	logic signed [XY_W-1:0]   x_d;
	logic signed [XY_W-1:0]   y_d;

	// ready chain
	assign adv3     = !vld_s3 || out_ready;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_ready = adv1;

	// stage 1 products
	always_comb begin
		r_d    = $signed({1'b0, in_item.range_mm});
		rsb_d  = r_d * in_item.sb;
		rcb_d  = r_d * in_item.cb;
		offs_d = axis_offset_mm * in_item.sa;
		offc_d = axis_offset_mm * in_item.ca;
	end

	// stage 2 products and z rounding
	always_comb begin
		px_d = ca_s1 * rsb_s1;
		py_d = sa_s1 * rsb_s1;
		zt_d = (RSB_W+1)'(rcb_s1) + (RSB_W+1)'(16384);
		zs_d = zt_d >>> 15;
		if (zs_d > (RSB_W+1)'(65535)) begin
			z_d = Z_W'(65535);
		end else if (zs_d < -(RSB_W+1)'(65536)) begin
			z_d = -Z_W'(65536);
		end else begin
			z_d = zs_d[Z_W-1:0];
		end
	end

	// stage 3 offset terms, rounding and saturation
	always_comb begin
		offx_d = SUM_W'(offs_s2);
		offx_d = offx_d <<< 15;
		offy_d = SUM_W'(offc_s2);
		offy_d = offy_d <<< 15;
		sx_d   = offx_d - SUM_W'(px_s2) + RND30;
		sy_d   = -offy_d - SUM_W'(py_s2) + RND30;
		xr_d   = sx_d >>> 30;
		yr_d   = sy_d >>> 30;
		if (xr_d > SUM_W'(131071)) begin
			x_d = XY_W'(131071);
		end else if (xr_d < -SUM_W'(131072)) begin
			x_d = -XY_W'(131072);
		end else begin
			x_d = xr_d[XY_W-1:0];
		end
		if (yr_d > SUM_W'(131071)) begin
			y_d = XY_W'(131071);
		end else if (yr_d < -SUM_W'(131072)) begin
			y_d = -XY_W'(131072);
		end else begin
			y_d = yr_d[XY_W-1:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			rsb_s1  <= rsb_d;
			rcb_s1  <= rcb_d;
			offs_s1 <= offs_d;
			offc_s1 <= offc_d;
			ca_s1   <= in_item.ca;
			sa_s1   <= in_item.sa;
		end
		if (adv2 && vld_s1) begin
			px_s2   <= px_d;
			py_s2   <= py_d;
			z_s2    <= z_d;
			offs_s2 <= offs_s1;
			offc_s2 <= offc_s1;
		end
		if (adv3 && vld_s2) begin
			x_s3 <= x_d;
			y_s3 <= y_d;
			z_s3 <= z_s2;
		end
	end

	assign out_valid = vld_s3;
	assign point_x   = x_s3;
	assign point_y   = y_s3;
	assign point_z   = z_s3;

endmodule

>>> src/rotating_scan_to_point_xyz.sv
// Converts range samples of a rotating 2D laser scanner into 3D points in millimetres:
// the beam phase is start_angle + beam_index * angle_step (one turn = 65536), sine and
// cosine of beam and scan phases come from two fully pipelined 20-step CORDIC lanes, and
// x = -cos(a)*r*sin(b) + off*sin(a), y = -sin(a)*r*sin(b) - off*cos(a), z = r*cos(b) are
// rounded half up and saturated. One transfer is taken every clock while the output is not
// stalled; a point passes through the beam phase stage, the 21 CORDIC registers (start vector
// and one per micro-rotation), the quadrant and rounding stage and three projection stages.
// Back-pressure is absorbed by the valid bits of the stages, so bubbles collapse under a stall.
// Registers must be written by the user through cfg_we/cfg_addr/cfg_wdata only while no
// sample is in flight; the block itself does not enforce this.
module rotating_scan_to_point_xyz import rspx_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// sample input
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_DATA_W-1:0]    s_axis_tdata,   // range_mm, beam_index, scan_angle, pad
	// point output
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // point_x, point_y, point_z, pad
	// configuration writes
	input  logic                    cfg_we,
	input  logic [CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [CFG_W-1:0]        cfg_wdata
);

	logic [PHASE_W-1:0]      start_angle_q;
	logic [PHASE_W-1:0]      angle_step_q;
	logic signed [OFF_W-1:0] axis_offset_q;

	logic [RANGE_W-1:0]             range_d;
	logic [INDEX_W-1:0]             index_d;
	logic [PHASE_W-1:0]             scan_d;
	logic [INDEX_W-1:0]             index_c;
	logic [INDEX_W+PHASE_W-1:0]     prod_d;
	logic [PHASE_W-1:0]             beam_d;

	logic               vld_s1;
	logic [RANGE_W-1:0] range_s1;
	logic [PHASE_W-1:0] beam_s1;
	logic [PHASE_W-1:0] scan_s1;
	logic               adv1;

	logic       cor_ready;
	logic       cor_valid;
	logic       prj_ready;
	trig_item_t cor_item;

	logic signed [XY_W-1:0] point_x;
	logic signed [XY_W-1:0] point_y;
	logic signed [Z_W-1:0]  point_z;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
			axis_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_START_ANGLE: start_angle_q <= cfg_wdata[PHASE_W-1:0];
				REG_ANGLE_STEP:  angle_step_q  <= cfg_wdata[PHASE_W-1:0];
				REG_AXIS_OFFSET: axis_offset_q <= $signed(cfg_wdata[OFF_W-1:0]);
				default: ;
			endcase
		end
	end

	// unpack the sample and form the beam phase
	always_comb begin
		range_d = s_axis_tdata[RANGE_W-1:0];
		index_d = s_axis_tdata[RANGE_W +: INDEX_W];
		scan_d  = s_axis_tdata[RANGE_W+INDEX_W +: PHASE_W];
		if (32'(index_d) >= 32'(MAX_BEAMS)) begin
			index_c = INDEX_W'(MAX_BEAMS - 1);
		end else begin
			index_c = index_d;
		end
		prod_d = index_c * angle_step_q;
		beam_d = start_angle_q + prod_d[PHASE_W-1:0];
	end

	// beam phase stage
	assign adv1          = !vld_s1 || cor_ready;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			range_s1 <= range_d;
			beam_s1  <= beam_d;
			scan_s1  <= scan_d;
		end
	end

	// sine and cosine of both phases
	rspx_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (cor_ready),
		.range_mm  (range_s1),
		.phase_b   (beam_s1),
		.phase_a   (scan_s1),
		.out_valid (cor_valid),
		.out_ready (prj_ready),
		.out_item  (cor_item)
	);

	// projection into the rotated frame
	rspx_project u_project (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (cor_valid),
		.in_ready       (prj_ready),
		.in_item        (cor_item),
		.axis_offset_mm (axis_offset_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.point_x        (point_x),
		.point_y        (point_y),
		.point_z        (point_z)
	);

	assign m_axis_tdata = {{(OUT_DATA_W-2*XY_W-Z_W){1'b0}}, point_z, point_y, point_x};

endmodule
